// File: design/assert_macros.svh
// assertion helpers for the design folder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked every clock, off during reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked every clock, off during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: design/agc_pkg.sv
`default_nettype none
package agc_pkg;
  localparam int MaxWordLen = 32;
  localparam int MaxGroups  = 64;
  localparam int LenW  = $clog2(MaxWordLen + 1);
  localparam int PosW  = $clog2(MaxWordLen);
  localparam int GrpW  = $clog2(MaxGroups + 1);
  localparam int GIdxW = $clog2(MaxGroups);
  localparam int KeyAw = GIdxW + PosW;
  localparam int IdxW  = 7;

  localparam logic CmdByte  = 1'b0;
  localparam logic CmdClear = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_CMP_LEN,
    ST_CMP_BYTE,
    ST_COPY,
    ST_DONE
  } state_e;
endpackage
`default_nettype wire

// File: design/anagram_group_classifier_top.sv
// anagram group classifier: a word arrives one byte per start beat (command
// clear empties the key table and word buffer). bytes are insertion-sorted
// into a word buffer one shift step per cycle, each step moving up one held
// byte greater than the new one. at the last byte the sorted key is
// compared against stored keys through a single registered key ram read
// port: a stored key whose length differs is skipped without a byte
// compare, and a key of equal length is compared byte by byte (the matching
// prefix plus the first differing byte); a new key is then copied into the
// ram one byte per cycle. busy stays high throughout. the result is shown
// for exactly one cycle with result_valid_o, registered from the done state;
// the receiver cannot stall, so it must take every result beat when it is shown.
// group_index_o is 64 with table_full_o when a new key finds the table full.
// the key ram needs no clearing pass: only entries below the group count are
// ever read.
`default_nettype none
`include "assert_macros.svh"
module anagram_group_classifier_top import agc_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire logic            command_i,
  input  wire logic [7:0]      ch_i,
  input  wire logic            word_end_i,
  output logic                 result_valid_o,
  output logic [IdxW-1:0]      group_index_o,
  output logic                 new_group_o,
  output logic                 too_long_o,
  output logic                 table_full_o
);

  state_e state_q, state_d;

  // sorted word buffer (registers, shifted in place)
  logic [7:0]      word_q [MaxWordLen];
  logic [LenW-1:0] len_q, len_d;
  logic            over_q, over_d;
  logic            end_q, end_d;
  logic [7:0]      ch_q, ch_d;
  logic [LenW-1:0] pos_q, pos_d;     // insertion slot walking down
  logic [GrpW-1:0] cnt_q, cnt_d;     // groups stored
  logic [GrpW-1:0] g_q, g_d;         // key under compare
  logic [LenW-1:0] k_q, k_d;         // byte index in compare / copy

  // key memory and length table
  logic [7:0]      key_mem [MaxGroups*MaxWordLen];
  logic [LenW-1:0] klen_mem [MaxGroups];
  logic [7:0]      key_rd_q;
  logic [LenW-1:0] klen_rd_q;
  logic            key_we, klen_we;
  logic [KeyAw-1:0] key_wa, key_ra;
  logic [GIdxW-1:0] grp_ra;

  logic [IdxW-1:0] res_idx_q, res_idx_d;
  logic            res_new_q, res_new_d, res_full_q, res_full_d;
  logic            res_vld_q, res_vld_d;

  // overlong flag captured at the result beat
  logic            over_q_r;

  logic            shift_en;
  logic [PosW-1:0] ins_at;
  logic            accept;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      len_q     <= '0;
      over_q    <= 1'b0;
      cnt_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      len_q     <= len_d;
      over_q    <= over_d;
      cnt_q     <= cnt_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    end_q      <= end_d;
    ch_q       <= ch_d;
    pos_q      <= pos_d;
    g_q        <= g_d;
    k_q        <= k_d;
    res_idx_q  <= res_idx_d;
    res_new_q  <= res_new_d;
    res_full_q <= res_full_d;
    if (shift_en) begin
      word_q[ins_at] <= word_q[ins_at - PosW'(1)];
    end else if (state_q == ST_INSERT) begin
      word_q[ins_at] <= ch_q;
    end
  end

  // key ram: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[key_wa] <= word_q[k_q[PosW-1:0]];
    key_rd_q <= key_mem[key_ra];
  end
  always_ff @(posedge clk_i) begin
    if (klen_we) klen_mem[cnt_q[GIdxW-1:0]] <= len_q;
    klen_rd_q <= klen_mem[grp_ra];
  end

  assign ins_at = pos_q[PosW-1:0];

  always_comb begin
    state_d    = state_q;
    len_d      = len_q;
    over_d     = over_q;
    end_d      = end_q;
    ch_d       = ch_q;
    pos_d      = pos_q;
    cnt_d      = cnt_q;
    g_d        = g_q;
    k_d        = k_q;
    res_idx_d  = res_idx_q;
    res_new_d  = res_new_q;
    res_full_d = res_full_q;
    res_vld_d  = 1'b0;
    shift_en   = 1'b0;
    key_we     = 1'b0;
    klen_we    = 1'b0;
    key_wa     = {cnt_q[GIdxW-1:0], k_q[PosW-1:0]};
    key_ra     = {g_q[GIdxW-1:0], k_q[PosW-1:0]};
    grp_ra     = g_q[GIdxW-1:0];
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (command_i == CmdClear) begin
            cnt_d  = '0;
            len_d  = '0;
            over_d = 1'b0;
          end else begin
            ch_d  = ch_i;
            end_d = word_end_i;
            pos_d = len_q;
            g_d   = '0;
            k_d   = '0;
            if (len_q == LenW'(MaxWordLen)) begin
              over_d  = 1'b1;
              state_d = word_end_i ? ST_CMP_LEN : ST_IDLE;
            end else begin
              state_d = ST_INSERT;
            end
          end
        end
      end
      ST_INSERT: begin
        // move one larger byte up, or drop the new byte in its slot
        if (pos_q != '0 && word_q[ins_at - PosW'(1)] > ch_q) begin
          shift_en = 1'b1;
          pos_d    = pos_q - LenW'(1);
        end else begin
          len_d   = len_q + LenW'(1);
          state_d = end_q ? ST_CMP_LEN : ST_IDLE;
        end
      end
      ST_CMP_LEN: begin
        // read address for key g length and byte k issued here
        if (g_q == cnt_q) begin
          res_new_d = 1'b1;
          k_d       = '0;
          if (cnt_q == GrpW'(MaxGroups)) begin
            res_idx_d  = IdxW'(MaxGroups);
            res_full_d = 1'b1;
            state_d    = ST_DONE;
          end else begin
            res_idx_d  = IdxW'(cnt_q);
            res_full_d = 1'b0;
            state_d    = ST_COPY;
          end
        end else begin
          state_d = ST_CMP_BYTE;
        end
      end
      ST_CMP_BYTE: begin
        // klen_rd_q and key_rd_q hold group g, byte k
        if (klen_rd_q != len_q) begin
          g_d = g_q + GrpW'(1);
          k_d = '0;
          key_ra = {g_d[GIdxW-1:0], k_d[PosW-1:0]};
          state_d = ST_CMP_LEN;
        end else if (k_q == len_q) begin
          res_idx_d  = IdxW'(g_q);
          res_new_d  = 1'b0;
          res_full_d = 1'b0;
          state_d    = ST_DONE;
        end else if (key_rd_q != word_q[k_q[PosW-1:0]]) begin
          g_d = g_q + GrpW'(1);
          k_d = '0;
          state_d = ST_CMP_LEN;
        end else begin
          k_d = k_q + LenW'(1);
          key_ra = {g_q[GIdxW-1:0], k_d[PosW-1:0]};
          if (k_d == len_q) begin
            res_idx_d  = IdxW'(g_q);
            res_new_d  = 1'b0;
            res_full_d = 1'b0;
            state_d    = ST_DONE;
          end else begin
            // wait in ST_CMP_LEN for the read of the next byte
            state_d = ST_CMP_LEN;
            g_d     = g_q;
          end
        end
      end
      ST_COPY: begin
        if (k_q == len_q) begin
          klen_we = 1'b1;
          cnt_d   = cnt_q + GrpW'(1);
          state_d = ST_DONE;
        end else begin
          key_we = 1'b1;
          k_d    = k_q + LenW'(1);
        end
      end
      ST_DONE: begin
        res_vld_d = 1'b1;
        len_d     = '0;
        over_d    = 1'b0;
        state_d   = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign result_valid_o = res_vld_q;
  assign group_index_o  = res_idx_q;
  assign new_group_o    = res_new_q;
  assign too_long_o     = res_vld_q & over_q_r;
  assign table_full_o   = res_full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) over_q_r <= 1'b0;
    else if (state_q == ST_DONE) over_q_r <= over_q;
  end

  `ASSERT_IMPL(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= GrpW'(MaxGroups),
               "group count beyond table size")
  `ASSERT_IMPL(a_full_new, clk_i, rst_ni, result_valid_o && table_full_o, new_group_o,
               "full table without new group")
  `ASSERT_IMPL(a_res_from_done, clk_i, rst_ni, result_valid_o, $past(state_q) == ST_DONE,
               "result beat without done state")
  `ASSERT_CLK(a_len_bound, clk_i, rst_ni, len_q <= LenW'(MaxWordLen),
              "word length beyond limit")

endmodule
`default_nettype wire

// File: dv/agc_scoreboard.sv
`timescale 1ns / 100ps
`default_nettype none
module agc_scoreboard import agc_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic            busy_i,
  input  wire logic            command_i,
  input  wire logic [7:0]      ch_i,
  input  wire logic            word_end_i,
  input  wire logic            result_valid_i,
  input  wire logic [IdxW-1:0] group_index_i,
  input  wire logic            new_group_i,
  input  wire logic            too_long_i,
  input  wire logic            table_full_i,
  output int                   errors_o,
  output int                   pending_o,
  output int                   words_o,
  output int                   new_groups_o,
  output int                   full_hits_o,
  output int                   overlong_o
);
  typedef struct packed {
    logic [IdxW-1:0] group_index;
    logic            new_group;
    logic            too_long;
    logic            table_full;
  } group_result_t;

  logic [7:0]      word_buf [MaxWordLen];
  int              word_len;
  logic            dropped;
  logic [7:0]      key_store [MaxGroups][MaxWordLen];
  int              key_len [MaxGroups];
  int              num_groups;
  group_result_t   expected_groups [$];

  function automatic logic key_equal(int g);
    if (key_len[g] != word_len) return 1'b0;
    for (int i = 0; i < word_len; i++)
      if (key_store[g][i] != word_buf[i]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic classify_byte(logic cmd, logic [7:0] b, logic last);
    group_result_t r;
    int pos;
    int hit;
    if (cmd == CmdClear) begin
      num_groups = 0;
      word_len = 0;
      dropped = 1'b0;
      return;
    end
    if (word_len < MaxWordLen) begin
      pos = word_len;
      while (pos > 0 && word_buf[pos-1] > b) begin
        word_buf[pos] = word_buf[pos-1];
        pos--;
      end
      word_buf[pos] = b;
      word_len++;
    end else begin
      dropped = 1'b1;
    end
    if (!last) return;
    hit = -1;
    for (int g = 0; g < num_groups; g++)
      if (hit < 0 && key_equal(g)) hit = g;
    r = '0;
    r.too_long = dropped;
    if (hit >= 0) begin
      r.group_index = IdxW'(hit);
    end else begin
      r.new_group = 1'b1;
      if (num_groups < MaxGroups) begin
        r.group_index = IdxW'(num_groups);
        for (int i = 0; i < word_len; i++) key_store[num_groups][i] = word_buf[i];
        key_len[num_groups] = word_len;
        num_groups++;
      end else begin
        r.group_index = IdxW'(MaxGroups);
        r.table_full = 1'b1;
      end
    end
    expected_groups.push_back(r);
    word_len = 0;
    dropped = 1'b0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    group_result_t e;
    if (!rst_ni) begin
      word_len = 0;
      dropped = 1'b0;
      num_groups = 0;
      expected_groups.delete();
      errors_o = 0;
      words_o = 0;
      new_groups_o = 0;
      full_hits_o = 0;
      overlong_o = 0;
    end else begin
      if (result_valid_i) begin
        if (expected_groups.size() == 0) begin
          $error("result beat with nothing expected");
          errors_o++;
        end else begin
          e = expected_groups.pop_front();
          words_o++;
          if (e.new_group) new_groups_o++;
          if (e.table_full) full_hits_o++;
          if (e.too_long) overlong_o++;
          if (group_index_i !== e.group_index) begin
            $error("group_index expected %0d actual %0d", e.group_index, group_index_i);
            errors_o++;
          end
          if (new_group_i !== e.new_group) begin
            $error("new_group expected %0b actual %0b", e.new_group, new_group_i);
            errors_o++;
          end
          if (too_long_i !== e.too_long) begin
            $error("too_long expected %0b actual %0b", e.too_long, too_long_i);
            errors_o++;
          end
          if (table_full_i !== e.table_full) begin
            $error("table_full expected %0b actual %0b", e.table_full, table_full_i);
            errors_o++;
          end
        end
      end
      if (start_i && !busy_i) classify_byte(command_i, ch_i, word_end_i);
    end
    pending_o = expected_groups.size();
  end
endmodule
`default_nettype wire

// File: dv/tb_anagram_group_classifier_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_anagram_group_classifier_top;
  import agc_pkg::*;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  logic            command_i = CmdByte;
  logic [7:0]      ch_i = '0;
  logic            word_end_i = 1'b0;
  logic            result_valid_o;
  logic [IdxW-1:0] group_index_o;
  logic            new_group_o;
  logic            too_long_o;
  logic            table_full_o;
  int              errors, pending, words, new_groups, full_hits, overlong;

  // beats sent so far and the bytes of recent words, reused to make anagrams
  int              beats_sent;
  logic [7:0]      recent_words [$][$];
  int              burst_left;

  always #2 clk_i = ~clk_i;

  anagram_group_classifier_top dut (
    .clk_i, .rst_ni, .start, .busy, .command_i, .ch_i, .word_end_i,
    .result_valid_o, .group_index_o, .new_group_o, .too_long_o, .table_full_o
  );

  agc_scoreboard u_scoreboard (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .command_i, .ch_i, .word_end_i,
    .result_valid_i(result_valid_o), .group_index_i(group_index_o),
    .new_group_i(new_group_o), .too_long_i(too_long_o), .table_full_i(table_full_o),
    .errors_o(errors), .pending_o(pending), .words_o(words),
    .new_groups_o(new_groups), .full_hits_o(full_hits), .overlong_o(overlong)
  );

  // hand one beat over: start stays high, the beat is taken at the first
  // rising edge with busy low (busy cannot move between negedge and posedge)
  task automatic send_beat(logic cmd, logic [7:0] b, logic last);
    start <= 1'b1;
    command_i <= cmd;
    ch_i <= b;
    word_end_i <= last;
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
    beats_sent++;
  endtask

  // sender idles in bursts: random burst length, random gap after it
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  task automatic send_word(logic [7:0] w [$]);
    for (int i = 0; i < w.size(); i++) begin
      send_beat(CmdByte, w[i], i == w.size() - 1);
      pace();
    end
  endtask

  task automatic send_clear();
    // ch and word_end are don't-care on a clear, so randomize them
    send_beat(CmdClear, 8'($urandom), 1'($urandom));
    pace();
  endtask

  // wait until the block is idle and every expected result has come,
  // looking at settled values between edges
  task automatic drain();
    do @(negedge clk_i); while (pending != 0 || busy);
  endtask

  function automatic void shuffle_word(ref logic [7:0] w [$]);
    logic [7:0] t;
    int j;
    for (int i = w.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = w[i];
      w[i] = w[j];
      w[j] = t;
    end
  endfunction

  initial begin
    logic [7:0] w [$];
    int n;
    beats_sent = 0;
    burst_left = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extreme bytes, zero byte as a normal value, anagram hit,
    // length mismatch, an overlong word, and a clear that restarts numbering
    w = '{8'h00};              send_word(w);
    w = '{8'hff};              send_word(w);
    w = '{8'h00, 8'hff, 8'h80}; send_word(w);
    w = '{8'h80, 8'h00, 8'hff}; send_word(w);
    w = '{8'hff, 8'h00};        send_word(w);
    w = {};
    for (int i = 0; i < 36; i++) w.push_back(8'($urandom));
    send_word(w);
    // same first 32 bytes plus a different tail: still the same group
    w[35] = ~w[35];
    send_word(w);
    send_clear();
    w = '{8'hff};              send_word(w);

    // hold off until the block has drained everything
    start <= 1'b0;
    drain();
    @(posedge clk_i);

    // random: mostly words, many of them anagrams of recent ones; lengths
    // mostly short, occasionally long or overlong; clears now and then so
    // the table fills up and overflows between them
    while (beats_sent < 1800) begin
      n = $urandom_range(0, 99);
      if (n < 2) begin
        send_clear();
      end else if (n < 45 && recent_words.size() > 0) begin
        w = recent_words[$urandom_range(0, recent_words.size() - 1)];
        shuffle_word(w);
        send_word(w);
      end else begin
        w = {};
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 5);
        for (int i = 0; i < n; i++)
          w.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(97, 100)));
        recent_words.push_back(w);
        if (recent_words.size() > 24) void'(recent_words.pop_front());
        send_word(w);
      end
    end
    start <= 1'b0;

    drain();
    repeat (50) @(posedge clk_i);
    $display("covered %0d beats, %0d words checked, %0d new groups", beats_sent, words,
             new_groups);
    $display("full-table words %0d, truncated words %0d", full_hits, overlong);
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // run limit, far above the slowest legal run
  initial begin
    #200ms;
    $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire
